// ===== src/uuid_pkg.sv =====
// ----------------------------------------------------------------------------
// UUID v7 generator package
// Shared constants, field layouts and the xorshift128+ step function.
// ----------------------------------------------------------------------------
package uuid_pkg;

  // Field widths
  localparam int unsigned TS_W   = 48;
  localparam int unsigned WORD_W = 64;

  // Number of discarded generator steps after seeding
  localparam int unsigned WARMUP_STEPS = 20;
  localparam int unsigned WARM_CNT_W   = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

  // Seeding mix constant
  localparam logic [WORD_W-1:0] GOLDEN_MIX = 64'h9E37_79B9_7F4A_7C15;

  // UUID layout constants
  localparam logic [3:0]  UUID_VERSION = 4'h7;
  localparam logic [1:0]  UUID_VARIANT = 2'b10;
  localparam int unsigned RAND_A_W     = 12;
  localparam int unsigned RAND_B_W     = 62;

  // xorshift128+ shift amounts
  localparam int unsigned XS_SHL  = 23;
  localparam int unsigned XS_SHR1 = 18;
  localparam int unsigned XS_SHR2 = 5;

  typedef struct packed {
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] rnd;
  } xs_result_t;

  // One xorshift128+ step: returns the new state and the output word.
  function automatic xs_result_t xs_step(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] nb;
    xs_result_t        res;
    x          = a ^ (a << XS_SHL);
    nb         = x ^ b ^ (x >> XS_SHR1) ^ (b >> XS_SHR2);
    res.word_a = b;
    res.word_b = nb;
    res.rnd    = nb + b;
    return res;
  endfunction

endpackage

// ===== src/uuid_req_if.sv =====
// ----------------------------------------------------------------------------
// UUID request channel
// Valid/ready channel carrying the millisecond timestamp of one request.
// ----------------------------------------------------------------------------
interface uuid_req_if;
  import uuid_pkg::*;

  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp_ms;

  modport source (output valid, output timestamp_ms, input ready);
  modport sink (input valid, input timestamp_ms, output ready);

endinterface

// ===== src/uuid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// UUID response channel
// Valid/ready channel carrying one 128-bit UUID as two 64-bit halves.
// ----------------------------------------------------------------------------
interface uuid_rsp_if;
  import uuid_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] uuid_high;
  logic [WORD_W-1:0] uuid_low;

  modport source (output valid, output uuid_high, output uuid_low, input ready);
  modport sink (input valid, input uuid_high, input uuid_low, output ready);

endinterface

// ===== src/uuid_v7_generator.sv =====
// ----------------------------------------------------------------------------
// UUID version 7 generator
// Builds a UUID v7 from a request timestamp and an xorshift128+ random source.
// ----------------------------------------------------------------------------
// Each request transaction returns one UUID transaction. A single xorshift128+
// step unit runs one step per cycle under a small sequencer, except while the
// sequencer holds in its last step: a request is taken in the idle state
// and then takes two steps, in S_R1 and S_R2, and its response register is
// loaded as S_R2 completes. The first request after reset loads the seed
// register into the generator and first runs 20 warm-up steps in S_WARM. The
// response sits in an output register, so a new request is accepted while a
// finished UUID waits to be taken; the sequencer holds in its last step only
// if that register is still full. The seed register may be written at any
// time but only takes effect on the first request after reset.
module uuid_v7_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         seed_we_i,
  input  logic [uuid_pkg::WORD_W-1:0]  seed_wdata_i,
  uuid_req_if.sink                     req_i,
  uuid_rsp_if.source                   rsp_o
);
  import uuid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WARM = 4'b0010,
    S_R1   = 4'b0100,
    S_R2   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic                   seeded_q, seeded_d;
  logic [WORD_W-1:0]      seed_q;
  logic [WORD_W-1:0]      a_q, a_d;
  logic [WORD_W-1:0]      b_q, b_d;
  logic [WARM_CNT_W-1:0]  cnt_q, cnt_d;
  logic [TS_W-1:0]        ts_q, ts_d;
  logic [RAND_A_W-1:0]    ra_q, ra_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic [WORD_W-1:0]      hi_q, hi_d;
  logic [WORD_W-1:0]      lo_q, lo_d;
  xs_result_t             xs;
  logic                   req_fire;
  logic                   out_free;
  logic                   last_warm;

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  // Shared generator step
  assign xs = xs_step(a_q, b_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && (state_q == S_IDLE);
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign last_warm   = (cnt_q == WARM_CNT_W'(WARMUP_STEPS - 1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    a_d         = a_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    ts_d        = ts_q;
    ra_d        = ra_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          ts_d  = req_i.timestamp_ms;
          cnt_d = '0;
          if (!seeded_q) begin
            seeded_d = 1'b1;
            a_d      = seed_q;
            b_d      = seed_q ^ GOLDEN_MIX;
            state_d  = (WARMUP_STEPS > 0) ? S_WARM : S_R1;
          end else begin
            state_d = S_R1;
          end
        end
      end
      S_WARM: begin
        a_d   = xs.word_a;
        b_d   = xs.word_b;
        cnt_d = cnt_q + WARM_CNT_W'(1);
        if (last_warm) begin
          state_d = S_R1;
        end
      end
      S_R1: begin
        a_d     = xs.word_a;
        b_d     = xs.word_b;
        ra_d    = xs.rnd[RAND_A_W-1:0];
        state_d = S_R2;
      end
      S_R2: begin
        // Hold here until the response register can take the result.
        if (out_free) begin
          a_d         = xs.word_a;
          b_d         = xs.word_b;
          hi_d        = {ts_q, UUID_VERSION, ra_q};
          lo_d        = {UUID_VARIANT, xs.rnd[RAND_B_W-1:0]};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      a_q         <= a_d;
      b_q         <= b_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
    ra_q <= ra_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.uuid_high = hi_q;
  assign rsp_o.uuid_low  = lo_q;

`ifndef SYNTH
  // The first accepted request always leaves the generator seeded.
  a_seed_on_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && !seeded_q |=> seeded_q)
    else $error("generator not seeded after first request");

  // A new response only appears out of the final generator step.
  a_rsp_from_r2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_R2))
    else $error("response appeared outside the final step");

  // Every response carries the version nibble and the variant bits.
  a_rsp_format : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (hi_q[15:12] == UUID_VERSION) &&
                    (lo_q[WORD_W-1:WORD_W-2] == UUID_VARIANT))
    else $error("response version or variant field is wrong");

  // The first random step is always followed by the second.
  a_r1_to_r2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_R1 |=> state_q == S_R2)
    else $error("first random step not followed by the second");
`endif

endmodule

// ===== test/tb_uuid_v7_generator.sv =====
// ----------------------------------------------------------------------------
// UUID version 7 generator testbench
// Drives timestamp requests through the valid/ready channel under varying
// idle patterns and two long response stalls. Every UUID that comes back is
// compared against a cycle-free xorshift128+ model of the generator.
// ----------------------------------------------------------------------------
module tb_uuid_v7_generator;
  import uuid_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 217;
  localparam int unsigned STALL_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [TS_W-1:0] TS_ALL_ONES = '1;

  typedef struct packed {
    logic [WORD_W-1:0] uuid_high;
    logic [WORD_W-1:0] uuid_low;
  } uuid_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              seed_we_i;
  logic [WORD_W-1:0] seed_wdata_i;

  uuid_req_if req_ch ();
  uuid_rsp_if rsp_ch ();

  uuid_v7_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_wdata_i (seed_wdata_i),
    .req_i        (req_ch),
    .rsp_o        (rsp_ch)
  );

  // Generator model state and the seed register copy.
  logic [WORD_W-1:0] prng_a = '0;
  logic [WORD_W-1:0] prng_b = '0;
  logic              prng_seeded = 1'b0;
  logic [WORD_W-1:0] seed_reg;

  logic [TS_W-1:0] pending_ts[$];
  uuid_t           expected_uuids[$];

  int unsigned queued_reqs   = 0;
  int unsigned accepted_reqs = 0;
  int unsigned uuids_seen    = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [TS_W-1:0] ts_clock;

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One xorshift128+ step on the model state; returns the output word.
  function automatic logic [WORD_W-1:0] prng_next();
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] mixed;
    s1     = prng_a;
    s0     = prng_b;
    s1     = s1 ^ (s1 << XS_SHL);
    mixed  = s1 ^ s0 ^ (s1 >> XS_SHR1) ^ (s0 >> XS_SHR2);
    prng_a = s0;
    prng_b = mixed;
    return mixed + s0;
  endfunction

  // Computes the UUID for one accepted request and queues it.
  task automatic predict_uuid(input logic [TS_W-1:0] ts);
    logic [WORD_W-1:0] r1;
    logic [WORD_W-1:0] r2;
    uuid_t             u;
    if (!prng_seeded) begin
      prng_a = seed_reg;
      prng_b = seed_reg ^ GOLDEN_MIX;
      for (int i = 0; i < WARMUP_STEPS; i++) void'(prng_next());
      prng_seeded = 1'b1;
    end
    r1 = prng_next();
    r2 = prng_next();
    u.uuid_high = {ts, UUID_VERSION, r1[RAND_A_W-1:0]};
    u.uuid_low  = {UUID_VARIANT, r2[RAND_B_W-1:0]};
    expected_uuids.push_back(u);
  endtask

  // Compares one received UUID with the oldest expected one.
  task automatic check_uuid(input logic [WORD_W-1:0] got_high,
                            input logic [WORD_W-1:0] got_low);
    uuid_t want;
    if (expected_uuids.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("tb: unexpected UUID %h_%h", got_high, got_low);
    end else begin
      want = expected_uuids.pop_front();
      if (got_high !== want.uuid_high || got_low !== want.uuid_low) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: UUID mismatch: expected %h_%h, got %h_%h",
                   want.uuid_high, want.uuid_low, got_high, got_low);
      end
    end
  endtask

  // Mix of fully random, extreme and clock-like timestamps.
  function automatic logic [TS_W-1:0] random_ts();
    logic [TS_W-1:0] ts;
    case ($urandom_range(9))
      0:       ts = '0;
      1:       ts = TS_ALL_ONES;
      2, 3, 4: ts = TS_W'({$urandom, $urandom});
      default: begin
        ts_clock = ts_clock + TS_W'($urandom_range(3));
        ts       = ts_clock;
      end
    endcase
    return ts;
  endfunction

  task automatic queue_request(input logic [TS_W-1:0] ts);
    pending_ts.push_back(ts);
    queued_reqs++;
  endtask

  // Waits until every request is accepted and every UUID has come back.
  task automatic wait_drained();
    while (accepted_reqs != queued_reqs || expected_uuids.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the seed register; the block must be idle.
  task automatic write_seed(input logic [WORD_W-1:0] value);
    @(posedge clk_i);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= value;
    seed_reg      = value;
    @(posedge clk_i);
    seed_we_i    <= 1'b0;
  endtask

  // Request driver: predicts on each accepted transaction, then offers the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid        <= 1'b0;
      req_ch.timestamp_ms <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_uuid(req_ch.timestamp_ms);
        accepted_reqs++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid        <= 1'b1;
          req_ch.timestamp_ms <= pending_ts.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure and two long stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_uuid(rsp_ch.uuid_high, rsp_ch.uuid_low);
        uuids_seen++;
        if (uuids_seen == 150 || uuids_seen == 520) stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [WORD_W-1:0] first_seed;
    seed_we_i           = 1'b0;
    seed_wdata_i        = '0;
    seed_reg            = '0;
    ts_clock            = 48'h0190_0000_0000;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The seed that counts: zero, all ones or random.
    case ($urandom_range(2))
      0:       first_seed = '0;
      1:       first_seed = '1;
      default: first_seed = {$urandom, $urandom};
    endcase
    write_seed(first_seed);

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 21;
    recv_idle_pct = 67;

    // Directed timestamps: extremes, bit patterns and repeats.
    queue_request('0);
    queue_request(TS_ALL_ONES);
    queue_request(48'h0000_0000_0001);
    queue_request(48'h8000_0000_0000);
    queue_request(48'hAAAA_AAAA_AAAA);
    queue_request(48'h5555_5555_5555);
    queue_request(48'h0000_FFFF_0000);
    queue_request(48'hFFFF_0000_FFFF);
    queue_request(48'h0190_0000_0000);
    queue_request(48'h0190_0000_0000);
    queue_request(48'h0190_0000_0001);
    queue_request(TS_ALL_ONES);
    queue_request('0);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_request(random_ts());
    wait_drained();

    // A seed written after seeding must leave the generator alone.
    write_seed('1);
    send_idle_pct = 67;
    recv_idle_pct = 21;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_request(random_ts());
    wait_drained();

    // Phase three: no idling on either side.
    write_seed('0);
    write_seed({$urandom, $urandom});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_request(random_ts());
    wait_drained();

    if (mismatches == 0 && expected_uuids.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
